@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file smc_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define SMC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define SMC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/smc_pkg.sv @@
// types and constants of the shuttle motor controller
// used by shuttle_motor_controller and smc_checker
package smc_pkg;

  localparam int unsigned ADC_BITS_DEFAULT = 10;
  localparam int unsigned CUR_LEVEL_W      = 10;
  localparam int unsigned LAMP_W           = 24;
  localparam int unsigned HOLDOFF_W        = 4;
  localparam int unsigned WINDOW_W         = 8;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [LAMP_W-1:0]    LAMP_PERIOD_RESET = LAMP_W'(15 * 60 * 1000);
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET     = HOLDOFF_W'(3);
  localparam logic [WINDOW_W-1:0]  WINDOW_RESET      = WINDOW_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_HOLDOFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_WINDOW = 2'd2;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_AT_A     = 3'd1,
    MODE_AT_B     = 3'd2,
    MODE_A_TO_B   = 3'd3,
    MODE_B_TO_A   = 3'd4,
    MODE_AB_PAUSE = 3'd5,
    MODE_BA_PAUSE = 3'd6
  } mode_e;

  typedef struct packed {
    logic                   op;
    logic                   touch;
    logic                   switch_a;
    logic                   switch_b;
    logic                   switch_c;
    logic [CUR_LEVEL_W-1:0] current_level;
  } in_item_t;

  typedef struct packed {
    logic       relay_toward_a;
    logic       relay_toward_b;
    logic       lamp_on;
    logic       led_a_lit;
    logic       beep;
    logic [2:0] run_state;
    logic       current_event;
  } out_item_t;

endpackage

@@ hdl/shuttle_motor_controller.sv @@
// shuttle motor controller: relay state machine, touch holdoff, current watchdog, lamp timer
// depends on smc_pkg
// the result of an accepted input transaction is registered in the output register
// throughput: one transaction per cycle, limited only by the single output register
// the output register frees in the cycle it is taken, so input ready follows output ready
// reset: asynchronous, active low; state, config and output valid reset, not output data
module shuttle_motor_controller
  import smc_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LAMP_W-1:0]    cfg_data_i
);

  localparam int unsigned CUR_W = (ADC_BITS < CUR_LEVEL_W) ? ADC_BITS : CUR_LEVEL_W;
  localparam int unsigned CMP_W = ((CUR_W > WINDOW_W) ? CUR_W : WINDOW_W) + 1;

  logic [LAMP_W-1:0]    lamp_period_q;
  logic [HOLDOFF_W-1:0] touch_holdoff_q;
  logic [WINDOW_W-1:0]  current_window_q;

  mode_e                mode_q, mode_d;
  logic                 drive_a_q, drive_a_d;
  logic                 drive_b_q, drive_b_d;
  logic                 lamp_q, lamp_d;
  logic                 timer_idle_q, timer_idle_d;
  logic [LAMP_W-1:0]    lamp_count_q, lamp_count_d;
  logic [CUR_W-1:0]     baseline_q, baseline_d;
  logic                 touch_locked_q, touch_locked_d;
  logic [HOLDOFF_W-1:0] holdoff_left_q, holdoff_left_d;
  logic                 led_a_q, led_a_d;

  logic                 out_valid_q;
  out_item_t            out_data_q, out_data_d;
  logic                 in_accept;
  logic                 beep_d, event_d;
  logic [CUR_W-1:0]     cur;
  logic [CMP_W-1:0]     hi, lo;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cur         = in_data_i.current_level[CUR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_period_q    <= LAMP_PERIOD_RESET;
      touch_holdoff_q  <= HOLDOFF_RESET;
      current_window_q <= WINDOW_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LAMP_PERIOD:    lamp_period_q    <= cfg_data_i;
        CFG_TOUCH_HOLDOFF:  touch_holdoff_q  <= cfg_data_i[HOLDOFF_W-1:0];
        CFG_CURRENT_WINDOW: current_window_q <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d         = mode_q;
    drive_a_d      = drive_a_q;
    drive_b_d      = drive_b_q;
    lamp_d         = lamp_q;
    timer_idle_d   = timer_idle_q;
    lamp_count_d   = lamp_count_q;
    baseline_d     = baseline_q;
    touch_locked_d = touch_locked_q;
    holdoff_left_d = holdoff_left_q;
    led_a_d        = led_a_q;
    beep_d         = 1'b0;
    event_d        = 1'b0;
    hi             = '0;
    lo             = '0;

    if (in_data_i.op == OP_TICK) begin
      if (!timer_idle_d) begin
        lamp_count_d = lamp_count_d + LAMP_W'(1);
        if (lamp_count_d >= lamp_period_q) begin
          lamp_count_d = '0;
          if (lamp_d) begin
            lamp_d       = 1'b0;
            timer_idle_d = 1'b1;
          end else begin
            lamp_d = 1'b1;
          end
        end
      end
    end else begin
      // holdoff countdown
      if (holdoff_left_d > touch_holdoff_q) holdoff_left_d = touch_holdoff_q;
      if (holdoff_left_d == '0) touch_locked_d = 1'b0;
      else holdoff_left_d = holdoff_left_d - HOLDOFF_W'(1);

      if (in_data_i.touch && !touch_locked_d) begin
        touch_locked_d = 1'b1;
        holdoff_left_d = touch_holdoff_q;
        beep_d         = 1'b1;
        unique case (mode_d)
          MODE_AT_A, MODE_BA_PAUSE: begin
            mode_d       = (mode_d == MODE_AT_A) ? MODE_A_TO_B : MODE_B_TO_A;
            drive_a_d    = 1'b0;
            drive_b_d    = 1'b1;
            baseline_d   = cur;
            timer_idle_d = 1'b1;
          end
          MODE_AT_B, MODE_AB_PAUSE: begin
            mode_d       = (mode_d == MODE_AT_B) ? MODE_B_TO_A : MODE_A_TO_B;
            drive_a_d    = 1'b1;
            drive_b_d    = 1'b0;
            baseline_d   = cur;
            timer_idle_d = 1'b1;
          end
          MODE_A_TO_B, MODE_B_TO_A: begin
            mode_d = (mode_d == MODE_A_TO_B) ? MODE_AB_PAUSE : MODE_BA_PAUSE;
            if (timer_idle_d) begin
              lamp_count_d = '0;
              timer_idle_d = 1'b0;
            end
            drive_a_d  = 1'b0;
            drive_b_d  = 1'b0;
            baseline_d = '0;
          end
          default: ;
        endcase
      end

      // limit switches
      if (in_data_i.switch_a) begin
        if (timer_idle_d) begin
          lamp_count_d = '0;
          timer_idle_d = 1'b0;
        end
        drive_a_d  = 1'b0;
        drive_b_d  = 1'b0;
        baseline_d = '0;
        mode_d     = MODE_AT_A;
        led_a_d    = 1'b0;
      end else begin
        led_a_d = 1'b1;
      end

      if (in_data_i.switch_b) begin
        if (timer_idle_d) begin
          lamp_count_d = '0;
          timer_idle_d = 1'b0;
        end
        drive_a_d  = 1'b0;
        drive_b_d  = 1'b0;
        baseline_d = '0;
        mode_d     = MODE_AT_B;
      end

      if (!in_data_i.switch_c && mode_d == MODE_A_TO_B) begin
        mode_d       = MODE_B_TO_A;
        drive_a_d    = 1'b1;
        drive_b_d    = 1'b0;
        baseline_d   = cur;
        timer_idle_d = 1'b1;
      end

      // current watchdog, lower bound saturates at zero
      if (baseline_d != '0) begin
        hi = CMP_W'(baseline_d) + CMP_W'(current_window_q);
        lo = (CMP_W'(baseline_d) >= CMP_W'(current_window_q)) ?
             CMP_W'(baseline_d) - CMP_W'(current_window_q) : '0;
        if (CMP_W'(cur) > hi || CMP_W'(cur) < lo) begin
          event_d    = 1'b1;
          baseline_d = cur;
        end
      end

      if (event_d && mode_d == MODE_B_TO_A) begin
        mode_d       = MODE_A_TO_B;
        drive_a_d    = 1'b0;
        drive_b_d    = 1'b1;
        baseline_d   = cur;
        timer_idle_d = 1'b1;
      end
    end

    out_data_d.relay_toward_a = drive_a_d;
    out_data_d.relay_toward_b = drive_b_d;
    out_data_d.lamp_on        = lamp_d;
    out_data_d.led_a_lit      = led_a_d;
    out_data_d.beep           = beep_d;
    out_data_d.run_state      = mode_d;
    out_data_d.current_event  = event_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_INIT;
      drive_a_q      <= 1'b1;
      drive_b_q      <= 1'b0;
      lamp_q         <= 1'b0;
      timer_idle_q   <= 1'b1;
      lamp_count_q   <= '0;
      baseline_q     <= '0;
      touch_locked_q <= 1'b0;
      holdoff_left_q <= '0;
      led_a_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_q         <= mode_d;
        drive_a_q      <= drive_a_d;
        drive_b_q      <= drive_b_d;
        lamp_q         <= lamp_d;
        timer_idle_q   <= timer_idle_d;
        lamp_count_q   <= lamp_count_d;
        baseline_q     <= baseline_d;
        touch_locked_q <= touch_locked_d;
        holdoff_left_q <= holdoff_left_d;
        led_a_q        <= led_a_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) out_data_q <= out_data_d;
  end

endmodule

@@ hdl/smc_checker.sv @@
// port-level checks for shuttle_motor_controller, attached by bind
// depends on smc_pkg and assert_macros.svh
`include "assert_macros.svh"

module smc_checker
  import smc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic stopped_mode;
  logic out_stall;
  logic both_relays;
  logic stopped_drive;
  logic event_in_ba;

  assign stopped_mode = out_data_o.run_state == MODE_AT_A
                     || out_data_o.run_state == MODE_AT_B
                     || out_data_o.run_state == MODE_AB_PAUSE
                     || out_data_o.run_state == MODE_BA_PAUSE;
  assign out_stall     = out_valid_o && !out_ready_i;
  assign both_relays   = out_data_o.relay_toward_a && out_data_o.relay_toward_b;
  assign stopped_drive = stopped_mode
                      && (out_data_o.relay_toward_a || out_data_o.relay_toward_b);
  assign event_in_ba   = out_data_o.current_event && out_data_o.run_state == MODE_B_TO_A;

  `SMC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o), "stall lost data")
  `SMC_ASSERT(a_no_accept_full, clk_i, rst_ni, out_stall |-> !in_ready_o, "input taken while full")
  `SMC_ASSERT(a_relays_exclusive, clk_i, rst_ni, out_valid_o |-> !both_relays, "both relays on")
  `SMC_ASSERT(a_stopped_relays_off, clk_i, rst_ni, out_valid_o |-> !stopped_drive, "stopped relay on")
  `SMC_ASSERT(a_event_reverses, clk_i, rst_ni, out_valid_o |-> !event_in_ba, "event kept B-to-A")

endmodule

bind shuttle_motor_controller smc_checker u_smc_checker (.*);
